/* design/pma_pkg.sv */
// ----------------------------------------------------------------------------
// pma_pkg: shared definitions for the alpha premultiply block
// types, constants and the elaboration-time builders of the sRGB tables
// ----------------------------------------------------------------------------
package pma_pkg;

	// default fixed-point configuration
	localparam int LINEAR_FRAC_BITS_DEF  = 16;
	localparam int ENCODE_INDEX_BITS_DEF = 12;

	// field widths
	localparam int CHAN_W     = 16;
	localparam int ENC_W      = 8;
	localparam int NUM_LANES  = 3;
	localparam int NUM_STAGES = 6;

	// configuration port
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 1;
	localparam logic [CFG_INDEX_W-1:0] REG_WIDE_CHANNELS = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SRGB_ENCODED  = 1'd1;

	// channel masks and rounding offsets
	localparam logic [CHAN_W-1:0] MASK_NARROW = 16'h00FF;
	localparam logic [CHAN_W-1:0] MASK_WIDE   = 16'hFFFF;
	localparam logic [CHAN_W-1:0] HALF_NARROW = 16'd127;
	localparam logic [CHAN_W-1:0] HALF_WIDE   = 16'd32767;

	// big-number width for the exact table builders
	localparam int BN_W = 384;

	// per-stage control handed from the top level to each lane
	typedef struct packed {
		logic [NUM_STAGES-1:0] en;
		logic                  srgb_s1;
		logic                  wide_s2;
		logic                  wide_s3;
		logic                  wide_s4;
	} lane_ctl_t;

	function automatic logic [BN_W-1:0] bn_pow(input int unsigned base, input int unsigned e);
		logic [BN_W-1:0] r;
		r = BN_W'(1);
		for (int unsigned i = 0; i < e; i++) begin
			r = r * BN_W'(base);
		end
		return r;
	endfunction

	// linear value of 8-bit sRGB code c in Q1.f, rounded half up, exact
	function automatic int unsigned dec_entry(input int unsigned c, input int unsigned f);
		logic [BN_W-1:0] q12;
		logic [BN_W-1:0] rhs;
		logic [BN_W-1:0] lhs;
		logic [BN_W-1:0] fac;
		logic [63:0]     num;
		int unsigned     lo;
		int unsigned     hi;
		int unsigned     mid;
		if (c <= 32'd10) begin
			num = 64'(200 * c) * (64'd1 << f) + 64'd329460;
			return 32'(num / 64'd658920);
		end
		q12 = bn_pow(269025, 12);
		rhs = bn_pow(1000 * c + 14025, 12) << (5 * (f + 1));
		lo = 0;
		hi = 1 << f;
		while (lo < hi) begin
			mid = lo + ((hi - lo + 1) >> 1);
			fac = BN_W'(2 * mid - 1);
			lhs = q12 * fac * fac * fac * fac * fac;
			if (lhs <= rhs) begin
				lo = mid;
			end else begin
				hi = mid - 1;
			end
		end
		return lo;
	endfunction

	// first encode index whose rounded 8-bit code reaches k, or 2^e if none
	function automatic int unsigned enc_thresh(input int unsigned k, input int unsigned e);
		logic [BN_W-1:0] big_q;
		logic [BN_W-1:0] rhs;
		logic [BN_W-1:0] lhs;
		logic [BN_W-1:0] fac;
		logic [63:0]     lin_l;
		logic [63:0]     lin_r;
		logic            hit;
		int unsigned     lo;
		int unsigned     hi;
		int unsigned     mid;
		big_q = bn_pow(538050, 12);
		rhs = bn_pow(1000 * (2 * k - 1) + 28050, 12) << (5 * e);
		lo = 0;
		hi = 1 << e;
		while (lo < hi) begin
			mid = lo + ((hi - lo) >> 1);
			if (64'(mid) * 64'd10000000 <= (64'd31308 << e)) begin
				lin_l = 64'd1292 * 64'd510 * 64'(mid);
				lin_r = (64'(2 * k - 1) * 64'd100) << e;
				hit = (lin_l >= lin_r);
			end else begin
				fac = BN_W'(mid);
				lhs = big_q * fac * fac * fac * fac * fac;
				hit = (lhs >= rhs);
			end
			if (hit) begin
				hi = mid;
			end else begin
				lo = mid + 1;
			end
		end
		return lo;
	endfunction

endpackage

/* design/pma_ram.sv */
// ----------------------------------------------------------------------------
// pma_ram: generic single-write, single-read memory
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module pma_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* design/pma_enc_fill.sv */
// ----------------------------------------------------------------------------
// pma_enc_fill: loads the sRGB encode table after reset
// walks the table once, stepping the code at each stored threshold
// ----------------------------------------------------------------------------
module pma_enc_fill #(
	parameter int ENCODE_INDEX_BITS = pma_pkg::ENCODE_INDEX_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	output logic                         busy,
	output logic                         we,
	output logic [ENCODE_INDEX_BITS-1:0] waddr,
	output logic [pma_pkg::ENC_W-1:0]    wdata
);

	localparam int TW    = ENCODE_INDEX_BITS + 1;
	localparam int DEPTH = 1 << ENCODE_INDEX_BITS;
	localparam int NCODE = 1 << pma_pkg::ENC_W;

	// threshold per code step; last slot is a sentinel that is never reached
	function automatic logic [NCODE*TW-1:0] build_thr();
		logic [NCODE*TW-1:0] t;
		t = '0;
		for (int k = 0; k < NCODE - 1; k++) begin
			t[k*TW +: TW] = TW'(pma_pkg::enc_thresh(k + 1, ENCODE_INDEX_BITS));
		end
		t[(NCODE-1)*TW +: TW] = TW'(DEPTH);
		return t;
	endfunction

	localparam logic [NCODE*TW-1:0] THR_TAB = build_thr();

	logic                         fill_q;
	logic [ENCODE_INDEX_BITS-1:0] idx_q;
	logic [pma_pkg::ENC_W-1:0]    code_q;
	logic [TW-1:0]                thr_c;
	logic                         step_c;

	assign thr_c  = THR_TAB[int'(code_q)*TW +: TW];
	assign step_c = (thr_c <= TW'(idx_q));

	assign busy  = fill_q;
	assign we    = fill_q && !step_c;
	assign waddr = idx_q;
	assign wdata = code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 1'b1;
			idx_q  <= '0;
			code_q <= '0;
		end else if (fill_q) begin
			if (step_c) begin
				code_q <= pma_pkg::ENC_W'(code_q + 1'b1);
			end else begin
				idx_q <= ENCODE_INDEX_BITS'(idx_q + 1'b1);
				if (idx_q == ENCODE_INDEX_BITS'(DEPTH - 1)) begin
					fill_q <= 1'b0;
				end
			end
		end
	end

endmodule

/* design/pma_lane.sv */
// ----------------------------------------------------------------------------
// pma_lane: one color channel of the premultiply pipeline
// decode, multiply by alpha, exact divide by the channel maximum, encode lookup
// ----------------------------------------------------------------------------
module pma_lane #(
	parameter int LINEAR_FRAC_BITS  = pma_pkg::LINEAR_FRAC_BITS_DEF,
	parameter int ENCODE_INDEX_BITS = pma_pkg::ENCODE_INDEX_BITS_DEF
) (
	input  logic                         clk,
	input  pma_pkg::lane_ctl_t           ctl,
	input  logic [pma_pkg::CHAN_W-1:0]   chan,
	input  logic [pma_pkg::CHAN_W-1:0]   alpha_s2,
	input  logic                         enc_we,
	input  logic [ENCODE_INDEX_BITS-1:0] enc_waddr,
	input  logic [pma_pkg::ENC_W-1:0]    enc_wdata,
	output logic [pma_pkg::ENC_W-1:0]    enc_s6,
	output logic [pma_pkg::CHAN_W-1:0]   lin_s6
);

	localparam int CW    = pma_pkg::CHAN_W;
	localparam int LW    = LINEAR_FRAC_BITS + 1;
	localparam int OW    = (LW > CW) ? LW : CW;
	localparam int XW    = (LINEAR_FRAC_BITS + 8 > 32) ? LINEAR_FRAC_BITS + 8 : 32;
	localparam int RW    = XW - 7;
	localparam int UP    = (ENCODE_INDEX_BITS > LINEAR_FRAC_BITS) ?
		ENCODE_INDEX_BITS - LINEAR_FRAC_BITS : 0;
	localparam int DN    = (LINEAR_FRAC_BITS > ENCODE_INDEX_BITS) ?
		LINEAR_FRAC_BITS - ENCODE_INDEX_BITS : 0;
	localparam int SW    = RW + UP;
	localparam int DEPTH = 1 << ENCODE_INDEX_BITS;
	localparam int NCODE = 1 << pma_pkg::ENC_W;

	// floor(2^XW / m) for m = 255 and m = 65535
	localparam logic [RW-1:0] RECIP_NARROW = RW'((64'd1 << XW) / 64'd255);
	localparam logic [RW-1:0] RECIP_WIDE   = RW'((64'd1 << XW) / 64'd65535);
	localparam logic [SW-1:0] IDX_TOP      = SW'(DEPTH - 1);

	function automatic logic [NCODE*LW-1:0] build_dec();
		logic [NCODE*LW-1:0] t;
		t = '0;
		for (int c = 0; c < NCODE; c++) begin
			t[c*LW +: LW] = LW'(pma_pkg::dec_entry(c, LINEAR_FRAC_BITS));
		end
		return t;
	endfunction

	localparam logic [NCODE*LW-1:0] DEC_TAB = build_dec();

	logic [CW-1:0]                c_s1;
	logic [OW-1:0]                op_s2;
	logic [XW-1:0]                x_s3;
	logic [XW-1:0]                x_s4;
	logic [RW-1:0]                q0_s4;
	logic [CW-1:0]                lin_s5;
	logic [ENCODE_INDEX_BITS-1:0] idx_s5;

	logic [LW-1:0]                dec_c;
	logic [OW+CW-1:0]             mul_c;
	logic [XW-1:0]                half_c;
	logic [XW-1:0]                x_c;
	logic [RW-1:0]                recip_c;
	logic [XW+RW-1:0]             prod_c;
	logic [RW-1:0]                q0_c;
	logic [XW+1:0]                back_c;
	logic [XW+1:0]                rem_c;
	logic [XW+1:0]                mod_c;
	logic [RW-1:0]                q_c;
	logic [SW-1:0]                sc_c;
	logic [ENCODE_INDEX_BITS-1:0] idx_c;

	// stage 2: sRGB decode or raw channel
	assign dec_c = DEC_TAB[int'(c_s1[pma_pkg::ENC_W-1:0])*LW +: LW];

	// stage 3: product with alpha plus half the divisor
	assign mul_c  = (OW+CW)'(op_s2) * (OW+CW)'(alpha_s2);
	assign half_c = ctl.wide_s2 ? XW'(pma_pkg::HALF_WIDE) : XW'(pma_pkg::HALF_NARROW);
	assign x_c    = XW'(mul_c) + half_c;

	// stage 4: reciprocal estimate, low by at most one
	assign recip_c = ctl.wide_s3 ? RECIP_WIDE : RECIP_NARROW;
	assign prod_c  = (XW+RW)'(x_s3) * (XW+RW)'(recip_c);
	assign q0_c    = RW'(prod_c >> XW);

	// stage 5: remainder check, divisor is 2^b - 1 so q0*m is a shift and subtract
	assign back_c = ctl.wide_s4 ? ((XW+2)'(q0_s4) << CW) : ((XW+2)'(q0_s4) << pma_pkg::ENC_W);
	assign rem_c  = (XW+2)'(x_s4) + (XW+2)'(q0_s4) - back_c;
	assign mod_c  = ctl.wide_s4 ? (XW+2)'(pma_pkg::MASK_WIDE) : (XW+2)'(pma_pkg::MASK_NARROW);
	assign q_c    = q0_s4 + RW'(rem_c >= mod_c);

	// top bits of the linear product, full scale clamps to the last entry
	assign sc_c  = (SW'(q_c) << UP) >> DN;
	assign idx_c = (sc_c > IDX_TOP) ? ENCODE_INDEX_BITS'(IDX_TOP) : ENCODE_INDEX_BITS'(sc_c);

	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			c_s1 <= chan;
		end
		if (ctl.en[1]) begin
			op_s2 <= ctl.srgb_s1 ? OW'(dec_c) : OW'(c_s1);
		end
		if (ctl.en[2]) begin
			x_s3 <= x_c;
		end
		if (ctl.en[3]) begin
			x_s4  <= x_s3;
			q0_s4 <= q0_c;
		end
		if (ctl.en[4]) begin
			lin_s5 <= CW'(q_c);
			idx_s5 <= idx_c;
		end
		if (ctl.en[5]) begin
			lin_s6 <= lin_s5;
		end
	end

	pma_ram #(
		.WIDTH (pma_pkg::ENC_W),
		.DEPTH (DEPTH)
	) u_enc_ram (
		.clk   (clk),
		.we    (enc_we),
		.waddr (enc_waddr),
		.wdata (enc_wdata),
		.re    (ctl.en[5]),
		.raddr (idx_s5),
		.rdata (enc_s6)
	);

endmodule

/* design/premultiply_alpha_texel_top.sv */
// ----------------------------------------------------------------------------
// premultiply_alpha_texel_top: RGBA texel alpha premultiplication
// three channel lanes in parallel, merged into one premultiplied texel
// ----------------------------------------------------------------------------
// takes one unsigned RGBA texel per cycle, unless stalled, and returns it
// with red, green and blue multiplied by alpha over full scale, rounded
// half up, alpha and the last marker passed through. channels are 8 bits
// (upper byte ignored and returned zero) or 16 bits, picked by
// wide_channels. in 8-bit mode with srgb_encoded set, each color channel
// is decoded to linear, scaled, and re-encoded through a table in block
// memory. throughput is one texel per clock while the output is not
// stalled: each of the three lanes has its own multipliers and its own
// encode memory read port, and the pipeline is six stages deep. empty
// stages keep filling while the output is stalled. after reset the encode
// tables are loaded by a sweep over all 2^ENCODE_INDEX_BITS entries,
// stepping the code at each threshold; in_stall stays high until it is
// done. configuration writes are taken at any time and should be made
// only while the pipeline is empty.
// ----------------------------------------------------------------------------
module premultiply_alpha_texel_top #(
	parameter int LINEAR_FRAC_BITS  = pma_pkg::LINEAR_FRAC_BITS_DEF,
	parameter int ENCODE_INDEX_BITS = pma_pkg::ENCODE_INDEX_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration writes
	input  logic                            cfg_wr_en,
	input  logic [pma_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [pma_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	// texel input
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [pma_pkg::CHAN_W-1:0]      red_in,
	input  logic [pma_pkg::CHAN_W-1:0]      green_in,
	input  logic [pma_pkg::CHAN_W-1:0]      blue_in,
	input  logic [pma_pkg::CHAN_W-1:0]      alpha_in,
	input  logic                            last_in,
	// texel output
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [pma_pkg::CHAN_W-1:0]      red_out,
	output logic [pma_pkg::CHAN_W-1:0]      green_out,
	output logic [pma_pkg::CHAN_W-1:0]      blue_out,
	output logic [pma_pkg::CHAN_W-1:0]      alpha_out,
	output logic                            last_out
);

	localparam int CW = pma_pkg::CHAN_W;
	localparam int NL = pma_pkg::NUM_LANES;

	// configuration registers
	logic wide_q;
	logic srgb_q;

	// encode table loader
	logic                         fill_busy;
	logic                         fill_we;
	logic [ENCODE_INDEX_BITS-1:0] fill_waddr;
	logic [pma_pkg::ENC_W-1:0]    fill_wdata;

	// pipeline occupancy and advance
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic free_s1, free_s2, free_s3, free_s4, free_s5, free_s6;
	logic in_xfer;

	// side data traveling with each texel
	logic [CW-1:0] alpha_s1, alpha_s2, alpha_s3, alpha_s4, alpha_s5, alpha_s6;
	logic          last_s1, last_s2, last_s3, last_s4, last_s5, last_s6;
	logic          srgb_s1, srgb_s2, srgb_s3, srgb_s4, srgb_s5, srgb_s6;
	logic          wide_s1, wide_s2, wide_s3, wide_s4;

	logic [CW-1:0]             mask_c;
	pma_pkg::lane_ctl_t        ctl;
	logic [CW-1:0]             chan_c [NL];
	logic [pma_pkg::ENC_W-1:0] enc_l  [NL];
	logic [CW-1:0]             lin_l  [NL];
	logic [CW-1:0]             res_c  [NL];

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_q <= 1'b0;
			srgb_q <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				pma_pkg::REG_WIDE_CHANNELS: wide_q <= cfg_wdata[0];
				pma_pkg::REG_SRGB_ENCODED:  srgb_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// a stage can take new data when it is empty or its texel moves on
	assign free_s6 = !valid_s6 || !out_stall;
	assign free_s5 = !valid_s5 || free_s6;
	assign free_s4 = !valid_s4 || free_s5;
	assign free_s3 = !valid_s3 || free_s4;
	assign free_s2 = !valid_s2 || free_s3;
	assign free_s1 = !valid_s1 || free_s2;

	// no transfers while the encode tables are being loaded
	assign in_stall = fill_busy || !free_s1;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (free_s1) begin
				valid_s1 <= in_xfer;
			end
			if (free_s2) begin
				valid_s2 <= valid_s1;
			end
			if (free_s3) begin
				valid_s3 <= valid_s2;
			end
			if (free_s4) begin
				valid_s4 <= valid_s3;
			end
			if (free_s5) begin
				valid_s5 <= valid_s4;
			end
			if (free_s6) begin
				valid_s6 <= valid_s5;
			end
		end
	end

	// 8-bit mode ignores the upper byte of every channel
	assign mask_c = wide_q ? pma_pkg::MASK_WIDE : pma_pkg::MASK_NARROW;

	always_ff @(posedge clk) begin
		if (free_s1) begin
			alpha_s1 <= alpha_in & mask_c;
			last_s1  <= last_in;
			srgb_s1  <= srgb_q && !wide_q; // sRGB only applies to 8-bit channels
			wide_s1  <= wide_q;
		end
		if (free_s2) begin
			alpha_s2 <= alpha_s1;
			last_s2  <= last_s1;
			srgb_s2  <= srgb_s1;
			wide_s2  <= wide_s1;
		end
		if (free_s3) begin
			alpha_s3 <= alpha_s2;
			last_s3  <= last_s2;
			srgb_s3  <= srgb_s2;
			wide_s3  <= wide_s2;
		end
		if (free_s4) begin
			alpha_s4 <= alpha_s3;
			last_s4  <= last_s3;
			srgb_s4  <= srgb_s3;
			wide_s4  <= wide_s3;
		end
		if (free_s5) begin
			alpha_s5 <= alpha_s4;
			last_s5  <= last_s4;
			srgb_s5  <= srgb_s4;
		end
		if (free_s6) begin
			alpha_s6 <= alpha_s5;
			last_s6  <= last_s5;
			srgb_s6  <= srgb_s5;
		end
	end

	// stage enables and per-stage mode bits shared by all lanes
	assign ctl.en      = {free_s6, free_s5, free_s4, free_s3, free_s2, free_s1};
	assign ctl.srgb_s1 = srgb_s1;
	assign ctl.wide_s2 = wide_s2;
	assign ctl.wide_s3 = wide_s3;
	assign ctl.wide_s4 = wide_s4;

	assign chan_c[0] = red_in & mask_c;
	assign chan_c[1] = green_in & mask_c;
	assign chan_c[2] = blue_in & mask_c;

	pma_enc_fill #(
		.ENCODE_INDEX_BITS (ENCODE_INDEX_BITS)
	) u_fill (
		.clk    (clk),
		.arst_n (arst_n),
		.busy   (fill_busy),
		.we     (fill_we),
		.waddr  (fill_waddr),
		.wdata  (fill_wdata)
	);

	// one lane per color channel, each with its own encode table copy
	for (genvar g = 0; g < NL; g++) begin : g_lane
		pma_lane #(
			.LINEAR_FRAC_BITS  (LINEAR_FRAC_BITS),
			.ENCODE_INDEX_BITS (ENCODE_INDEX_BITS)
		) u_lane (
			.clk       (clk),
			.ctl       (ctl),
			.chan      (chan_c[g]),
			.alpha_s2  (alpha_s2),
			.enc_we    (fill_we),
			.enc_waddr (fill_waddr),
			.enc_wdata (fill_wdata),
			.enc_s6    (enc_l[g]),
			.lin_s6    (lin_l[g])
		);

		// merge: encoded code in sRGB mode, linear quotient otherwise
		assign res_c[g] = srgb_s6 ? CW'(enc_l[g]) : lin_l[g];
	end

	assign out_valid = valid_s6;
	assign red_out   = res_c[0];
	assign green_out = res_c[1];
	assign blue_out  = res_c[2];
	assign alpha_out = alpha_s6;
	assign last_out  = last_s6;

endmodule

/* verif/tb_premultiply_alpha_texel_top.sv */
// ----------------------------------------------------------------------------
// tb_premultiply_alpha_texel_top: self-checking bench for the premultiply block
// drives texels through the valid/stall handshake under all four register
// settings, predicts each premultiplied texel with exact sRGB tables built at
// start-up, and compares every result transfer field by field in order
// ----------------------------------------------------------------------------
module tb_premultiply_alpha_texel_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CHAN_W      = pma_pkg::CHAN_W;
	localparam int CFG_INDEX_W = pma_pkg::CFG_INDEX_W;
	localparam int CFG_DATA_W  = pma_pkg::CFG_DATA_W;

	// fixed-point setting of the instance, defaults of the block
	localparam int FRAC_BITS   = pma_pkg::LINEAR_FRAC_BITS_DEF;
	localparam int INDEX_BITS  = pma_pkg::ENCODE_INDEX_BITS_DEF;
	// table-loading sweep after reset plus ~1500 texels with random gaps and stalls
	localparam int CYCLE_LIMIT = 200000;

	typedef logic [319:0] exact_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] alpha;
		logic              last_flag;
	} texel_t;

	// ------------------------------------------------------------------------
	// expected-texel store with its own premultiply predictor
	// ------------------------------------------------------------------------
	class premul_scoreboard;
		bit                 wide_channels;
		bit                 srgb_encoded;
		bit                 failed;
		texel_t             pending_texels[$];
		logic [FRAC_BITS:0] linear_of_code[256];
		logic [7:0]         code_of_linear[1 << INDEX_BITS];
		exact_t             encode_den;

		function new();
			wide_channels = 1'b0;
			srgb_encoded  = 1'b0;
			failed        = 1'b0;
			encode_den    = raise(538050, 12);
			build_decode_table();
			build_encode_table();
		endfunction

		// square-and-multiply power, exact within 320 bits
		static function exact_t raise(int unsigned base, int unsigned n);
			exact_t acc;
			exact_t sq;
			acc = 1;
			sq  = base;
			while (n != 0) begin
				if (n & 1) begin
					acc = acc * sq;
				end
				sq = sq * sq;
				n  = n >> 1;
			end
			return acc;
		endfunction

		// sRGB code to linear Q1.16, round half up, exact comparisons
		function void build_decode_table();
			exact_t          den;
			exact_t          lim;
			exact_t          odd;
			exact_t          trial;
			int unsigned     lo;
			int unsigned     hi;
			int unsigned     mid;
			longint unsigned num;
			den = raise(269025, 12);
			for (int c = 0; c < 256; c++) begin
				if (c <= 10) begin
					// straight-line segment
					num = (longint'(200 * c) << FRAC_BITS) + 64'd329460;
					linear_of_code[c] = (FRAC_BITS + 1)'(num / 64'd658920);
				end else begin
					lim = raise(1000 * c + 14025, 12) << (5 * (FRAC_BITS + 1));
					lo  = 0;
					hi  = 1 << FRAC_BITS;
					while (lo < hi) begin
						mid   = (lo + hi + 1) >> 1;
						odd   = 2 * mid - 1;
						trial = den * odd * odd * odd * odd * odd;
						if (trial <= lim) begin
							lo = mid;
						end else begin
							hi = mid - 1;
						end
					end
					linear_of_code[c] = lo[FRAC_BITS:0];
				end
			end
		endfunction

		// does encode index i round to code k or above
		function bit reaches_code(int unsigned i, int unsigned k);
			exact_t          lhs;
			exact_t          rhs;
			exact_t          ie;
			longint unsigned lin_l;
			longint unsigned lin_r;
			if (64'(i) * 64'd10000000 <= (64'd31308 << INDEX_BITS)) begin
				lin_l = 64'd658920 * 64'(i);
				lin_r = (64'(2 * k - 1) * 64'd100) << INDEX_BITS;
				return lin_l >= lin_r;
			end
			ie  = i;
			lhs = encode_den * ie * ie * ie * ie * ie;
			rhs = raise(1000 * (2 * k - 1) + 28050, 12) << (5 * INDEX_BITS);
			return lhs >= rhs;
		endfunction

		// one sweep over the index, the code only ever climbs
		function void build_encode_table();
			int unsigned code;
			code = 0;
			for (int unsigned i = 0; i < (1 << INDEX_BITS); i++) begin
				while (code < 255 && reaches_code(i, code + 1)) begin
					code++;
				end
				code_of_linear[i] = code[7:0];
			end
		endfunction

		function logic [CHAN_W-1:0] scale_channel(logic [CHAN_W-1:0] chan,
				logic [CHAN_W-1:0] alpha, logic [CHAN_W-1:0] full);
			longint unsigned c64;
			longint unsigned a64;
			longint unsigned f64;
			longint unsigned prod;
			longint unsigned idx;
			c64 = chan;
			a64 = alpha;
			f64 = full;
			if (!wide_channels && srgb_encoded) begin
				prod = (2 * 64'(linear_of_code[chan[7:0]]) * a64 + 255) / 510;
				idx  = prod >> (FRAC_BITS - INDEX_BITS);
				// full-scale product lands one past the table
				if (idx > (1 << INDEX_BITS) - 1) begin
					idx = (1 << INDEX_BITS) - 1;
				end
				return CHAN_W'(code_of_linear[idx]);
			end
			return CHAN_W'((2 * c64 * a64 + f64) / (2 * f64));
		endfunction

		function texel_t premultiply(texel_t t);
			texel_t            r;
			logic [CHAN_W-1:0] full;
			full        = wide_channels ? pma_pkg::MASK_WIDE : pma_pkg::MASK_NARROW;
			r.alpha     = t.alpha & full;
			r.red       = scale_channel(t.red & full, r.alpha, full);
			r.green     = scale_channel(t.green & full, r.alpha, full);
			r.blue      = scale_channel(t.blue & full, r.alpha, full);
			r.last_flag = t.last_flag;
			return r;
		endfunction

		function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				pma_pkg::REG_WIDE_CHANNELS: wide_channels = val[0];
				pma_pkg::REG_SRGB_ENCODED:  srgb_encoded  = val[0];
				default: ;
			endcase
		endfunction

		function void note_texel(texel_t t);
			pending_texels = {pending_texels, premultiply(t)};
		endfunction

		function int outstanding();
			return pending_texels.size();
		endfunction

		function void compare_field(string field, logic [CHAN_W-1:0] want,
				logic [CHAN_W-1:0] got);
			if (want !== got) begin
				$display("%0t: %s expected %h actual %h", $time, field, want, got);
				failed = 1'b1;
			end
		endfunction

		function void check_texel(texel_t got);
			texel_t want;
			if (pending_texels.size() == 0) begin
				$display("%0t: result transfer with nothing pending, expected none actual %h",
					$time, got);
				failed = 1'b1;
				return;
			end
			want = pending_texels.pop_front();
			compare_field("red_out", want.red, got.red);
			compare_field("green_out", want.green, got.green);
			compare_field("blue_out", want.blue, got.blue);
			compare_field("alpha_out", want.alpha, got.alpha);
			compare_field("last_out", CHAN_W'(want.last_flag), CHAN_W'(got.last_flag));
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// block signals, all inputs known from time zero
	// ------------------------------------------------------------------------
	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_wr_en = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
	logic                   in_valid  = 1'b0;
	logic                   in_stall;
	logic [CHAN_W-1:0]      red_in    = '0;
	logic [CHAN_W-1:0]      green_in  = '0;
	logic [CHAN_W-1:0]      blue_in   = '0;
	logic [CHAN_W-1:0]      alpha_in  = '0;
	logic                   last_in   = 1'b0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [CHAN_W-1:0]      red_out;
	logic [CHAN_W-1:0]      green_out;
	logic [CHAN_W-1:0]      blue_out;
	logic [CHAN_W-1:0]      alpha_out;
	logic                   last_out;

	// when set, neither side idles: a long back-to-back stretch
	bit               no_gaps = 1'b0;
	int               cycle_count = 0;
	premul_scoreboard scoreboard;

	premultiply_alpha_texel_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.alpha_in  (alpha_in),
		.last_in   (last_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out),
		.alpha_out (alpha_out),
		.last_out  (last_out)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// receiver: stalls at random about 27 percent of the time, none during calm stretches
	always @(negedge clk) begin
		out_stall <= (no_gaps || !arst_n) ? 1'b0 : ($urandom_range(0, 99) < 27);
	end

	// every result transfer goes to the scoreboard, sampled at the edge that takes it
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			scoreboard.check_texel('{red_out, green_out, blue_out, alpha_out, last_out});
		end
	end

	// ------------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------------

	// one register write, only ever called with the pipeline empty
	task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		scoreboard.set_register(idx, val);
	endtask

	// offer one texel, with random idle cycles ahead of it, hold until taken
	task automatic send_texel(texel_t t);
		@(negedge clk);
		while (!no_gaps && $urandom_range(0, 99) < 27) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		red_in   <= t.red;
		green_in <= t.green;
		blue_in  <= t.blue;
		alpha_in <= t.alpha;
		last_in  <= t.last_flag;
		@(posedge clk);
		// stays high through the table-loading sweep after reset
		while (in_stall) begin
			@(posedge clk);
		end
		scoreboard.note_texel(t);
	endtask

	// sender goes quiet until every pending texel has come back
	task automatic drain_texels();
		@(negedge clk);
		in_valid <= 1'b0;
		while (scoreboard.outstanding() != 0) begin
			@(posedge clk);
		end
	endtask

	// corners: zero and full scale on color and alpha, garbage upper bytes,
	// short sRGB codes on the straight segment, full-scale sRGB product
	task automatic run_corner_texels();
		send_texel('{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0});
		send_texel('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1});
		send_texel('{16'hFFFF, 16'h0000, 16'h00FF, 16'h0000, 1'b0});
		send_texel('{16'h0000, 16'hFFFF, 16'h8000, 16'hFFFF, 1'b0});
		send_texel('{16'hFF01, 16'h0080, 16'h7F7F, 16'h01FF, 1'b1});
		send_texel('{16'h00C0, 16'h0005, 16'h0A0B, 16'h0080, 1'b0});
	endtask

	function automatic texel_t random_texel();
		texel_t t;
		t.red       = CHAN_W'($urandom);
		t.green     = CHAN_W'($urandom);
		t.blue      = CHAN_W'($urandom);
		t.alpha     = CHAN_W'($urandom);
		t.last_flag = 1'($urandom);
		case ($urandom_range(0, 9))
			0: t.alpha = pma_pkg::MASK_WIDE;
			1: t.alpha = '0;
			// opaque in 8-bit mode, junk upper byte
			2: t.alpha = pma_pkg::MASK_NARROW | (CHAN_W'($urandom) & 16'hFF00);
			3: begin
				t.red   = pma_pkg::MASK_WIDE;
				t.green = '0;
			end
			default: ;
		endcase
		return t;
	endfunction

	// one register setting: write both registers, corners if with_corners is set, then random texels
	task automatic run_phase(bit wide, bit srgb, bit with_corners, int count,
			int calm_from, int calm_to, int pause_at);
		write_register(pma_pkg::REG_WIDE_CHANNELS, wide);
		write_register(pma_pkg::REG_SRGB_ENCODED, srgb);
		if (with_corners) begin
			run_corner_texels();
		end
		for (int n = 0; n < count; n++) begin
			no_gaps = (n >= calm_from && n < calm_to);
			if (n == pause_at) begin
				drain_texels();
			end
			send_texel(random_texel());
		end
		no_gaps = 1'b0;
		drain_texels();
	endtask

	// ------------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------------
	initial begin
		scoreboard = new();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// linear 8-bit, sRGB 8-bit with a mid-phase drain, linear 16-bit with a
		// calm opening stretch, sRGB flag under 16-bit (ignored), then revisits
		run_phase(1'b0, 1'b0, 1'b1, 240, -1, -1, -1);
		run_phase(1'b0, 1'b1, 1'b1, 240, -1, -1, 120);
		run_phase(1'b1, 1'b0, 1'b1, 240, 0, 130, -1);
		run_phase(1'b1, 1'b1, 1'b1, 240, -1, -1, -1);
		run_phase(1'b0, 1'b1, 1'b0, 240, 60, 160, -1);
		run_phase(1'b0, 1'b0, 1'b0, 240, -1, -1, -1);

		// settle past the six-stage pipeline in case of stray results
		repeat (16) @(posedge clk);
		if (!scoreboard.failed && scoreboard.outstanding() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
